[design/brb_pkg.sv]
// brb_pkg: shared types and constants for the byte ring buffer fifo
// request and result structs, action codes, sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

	localparam int DATA_W  = 8;
	localparam int LEN_W   = 7;
	localparam int USED_W  = 9;

	localparam int DEPTH_DEF     = 256;
	localparam int MAX_BURST_DEF = 64;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	typedef struct packed {
		logic              action;
		logic [DATA_W-1:0] write_data;
		logic [LEN_W-1:0]  read_length;
	} brb_req_t;

	typedef struct packed {
		logic              accepted;
		logic [DATA_W-1:0] read_byte;
		logic              last;
		logic [USED_W-1:0] used_count;
	} brb_rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} brb_state_t;

endpackage

`default_nettype wire

[design/byte_ring_buffer_fifo.sv]
// byte_ring_buffer_fifo: circular byte store with write, burst read and used count
// depends on brb_pkg (request/result structs, action codes, state enum)
// storage is one 1-write / 1-read synchronous ram inside this module
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+-----------------------------------
//  request   | start, busy, item          | taken at edge with start & !busy
//  result    | strobe, result             | one strobe per result, no backpressure
//
// a write request's result shows in the cycle after it is taken
// a read request of n returned bytes (n = min(used, length, MAX_BURST)) holds
//   busy after its first byte until its last ram read issues; one ram read issues per cycle, results
//   stream one per cycle, each in the cycle after its ram read, the ram read port sets that rate
// an empty or zero-length read gives one result in the cycle after it is taken, like a write
// reset clears indices and count; ram contents are left as they are
// the receiver cannot stall, so results are never held
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_fifo #(
	parameter int DEPTH     = brb_pkg::DEPTH_DEF,
	parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire brb_pkg::brb_req_t item,
	output logic                   strobe,
	output brb_pkg::brb_rsp_t      result
);

	import brb_pkg::*;

	// index, count and burst widths
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int MW = (CW > LEN_W) ? CW : LEN_W;

	// byte storage, one write port and one registered read port
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// control state
	brb_state_t    state_q, state_d;
	logic [AW-1:0] widx_q, widx_d;
	logic [AW-1:0] ridx_q, ridx_d;
	logic [CW-1:0] used_q, used_d;
	logic [BW-1:0] remain_q, remain_d;

	// result stage, lined up with the ram read data
	logic              vld_s1, vld_d;
	logic              acc_s1, acc_d;
	logic              last_s1, last_d;
	logic              rd_s1, rd_d;
	logic [USED_W-1:0] used_s1, used_out_d;

	// ram access strobes
	logic wr_en;
	logic rd_en;

	// request decode helpers
	logic          take;
	logic          full;
	logic [MW-1:0] req_w;
	logic [MW-1:0] used_w;
	logic [MW-1:0] len_w;
	logic [BW-1:0] len;

	assign take = start && !busy;
	assign full = (used_q == CW'(DEPTH));

	// clip the requested length, then to what is held
	always_comb begin
		used_w = MW'(used_q);
		if (MW'(item.read_length) > MW'(MAX_BURST)) begin
			req_w = MW'(MAX_BURST);
		end else begin
			req_w = MW'(item.read_length);
		end
		len_w = (used_w < req_w) ? used_w : req_w;
		len   = BW'(len_w);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			widx_q   <= '0;
			ridx_q   <= '0;
			used_q   <= '0;
			remain_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			state_q  <= state_d;
			widx_q   <= widx_d;
			ridx_q   <= ridx_d;
			used_q   <= used_d;
			remain_q <= remain_d;
			vld_s1   <= vld_d;
		end
	end

	// result payload needs no reset
	always_ff @(posedge clk) begin
		acc_s1  <= acc_d;
		last_s1 <= last_d;
		rd_s1   <= rd_d;
		used_s1 <= used_out_d;
	end

	// next state, ram strobes and result fields
	always_comb begin
		state_d    = state_q;
		widx_d     = widx_q;
		ridx_d     = ridx_q;
		used_d     = used_q;
		remain_d   = remain_q;
		vld_d      = 1'b0;
		acc_d      = 1'b0;
		last_d     = 1'b1;
		rd_d       = 1'b0;
		used_out_d = USED_W'(used_q);
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		busy       = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					vld_d = 1'b1;
					if (item.action == ACT_WRITE) begin
						// byte dropped when full, count reported as is
						if (!full) begin
							wr_en      = 1'b1;
							widx_d     = (widx_q == AW'(DEPTH - 1)) ? '0 : widx_q + 1'b1;
							used_d     = used_q + 1'b1;
							acc_d      = 1'b1;
							used_out_d = USED_W'(used_q + 1'b1);
						end
					end else if (len != '0) begin
						// ram read for the first byte of the burst issues this cycle
						rd_en      = 1'b1;
						rd_d       = 1'b1;
						acc_d      = 1'b1;
						ridx_d     = (ridx_q == AW'(DEPTH - 1)) ? '0 : ridx_q + 1'b1;
						used_d     = used_q - 1'b1;
						used_out_d = USED_W'(used_q - 1'b1);
						last_d     = (len == BW'(1));
						remain_d   = len - 1'b1;
						if (len != BW'(1)) begin
							state_d = ST_READ;
						end
					end
				end
			end
			ST_READ: begin
				// rest of the burst, one byte a cycle
				busy       = 1'b1;
				vld_d      = 1'b1;
				rd_en      = 1'b1;
				rd_d       = 1'b1;
				acc_d      = 1'b1;
				ridx_d     = (ridx_q == AW'(DEPTH - 1)) ? '0 : ridx_q + 1'b1;
				used_d     = used_q - 1'b1;
				used_out_d = USED_W'(used_q - 1'b1);
				last_d     = (remain_q == BW'(1));
				remain_d   = remain_q - 1'b1;
				if (remain_q == BW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ram: write at the write index, registered read at the read index
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[widx_q] <= item.write_data;
		end
		if (rd_en) begin
			rdata_q <= mem[ridx_q];
		end
	end

	// result ports straight from the stage registers
	assign strobe            = vld_s1;
	assign result.accepted   = acc_s1;
	assign result.read_byte  = rd_s1 ? rdata_q : '0;
	assign result.last       = last_s1;
	assign result.used_count = used_s1;

	// count never passes the store size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(DEPTH))
		else $error("used count above depth");

	// a burst in progress always has bytes left to fetch
	a_burst_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (remain_q != '0))
		else $error("burst state with nothing left");

	// a ram read only issues when a byte is held
	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (used_q != '0))
		else $error("read issued on empty store");

	// a result without last is followed by another result
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |=> strobe)
		else $error("burst broken before last");

endmodule

`default_nettype wire

[test/tb_byte_ring_buffer_fifo.sv]
// tb_byte_ring_buffer_fifo: self-checking testbench for the byte ring buffer fifo
// keeps its own copy of the ring store and indices and checks every result it streams
// depends on brb_pkg and byte_ring_buffer_fifo
`timescale 1ns / 1ps

module tb_byte_ring_buffer_fifo;

	import brb_pkg::*;

	localparam int          RING_DEPTH   = DEPTH_DEF;
	localparam int          BURST_MAX    = MAX_BURST_DEF;
	localparam int          IDX_W        = $clog2(RING_DEPTH);
	// wait after the last owed result, sized from the longest burst
	localparam int          DRAIN_CYCLES = BURST_MAX + 8;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	brb_req_t item;
	logic     strobe;
	brb_rsp_t result;

	// copy of the block state, advanced once per taken request
	logic [DATA_W-1:0] ring_copy [RING_DEPTH];
	logic [IDX_W-1:0]  copy_wr_idx = '0;
	logic [IDX_W-1:0]  copy_rd_idx = '0;
	logic              copy_full   = 1'b0;

	// results still owed by the block, oldest first
	brb_rsp_t    awaited_rsp [$];
	int unsigned fail_count  = 0;
	int unsigned cycle_count = 0;
	// chance in a hundred that the sender sits out a cycle
	int unsigned idle_pct    = 0;

	byte_ring_buffer_fifo u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	// bytes held by the copy; equal indices mean empty unless the full flag is set
	function automatic int unsigned copy_used();
		if (copy_full) begin
			return RING_DEPTH;
		end
		return int'(IDX_W'(copy_wr_idx - copy_rd_idx));
	endfunction

	// advance the copy by one accepted request and queue the results it owes
	task automatic predict_ring_access(input brb_req_t req);
		brb_rsp_t    rsp;
		int unsigned held;
		int unsigned want;
		int unsigned count;
		held = copy_used();
		rsp = '0;
		rsp.last = 1'b1;
		if (req.action == ACT_WRITE) begin
			// a write into a full ring is dropped and leaves the state alone
			if (held < RING_DEPTH) begin
				ring_copy[copy_wr_idx] = req.write_data;
				copy_wr_idx = copy_wr_idx + 1'b1;
				if (copy_wr_idx == copy_rd_idx) begin
					copy_full = 1'b1;
				end
				rsp.accepted = 1'b1;
			end
			rsp.used_count = USED_W'(copy_used());
			awaited_rsp.push_back(rsp);
		end else begin
			// oversized lengths saturate, short reads return what is held
			want = (req.read_length > BURST_MAX) ? BURST_MAX : req.read_length;
			count = (held < want) ? held : want;
			if (count == 0) begin
				rsp.used_count = USED_W'(held);
				awaited_rsp.push_back(rsp);
			end else begin
				for (int unsigned i = 0; i < count; i++) begin
					rsp.accepted = 1'b1;
					rsp.read_byte = ring_copy[copy_rd_idx];
					copy_rd_idx = copy_rd_idx + 1'b1;
					copy_full = 1'b0;
					rsp.last = (i + 1 == count);
					rsp.used_count = USED_W'(copy_used());
					awaited_rsp.push_back(rsp);
				end
			end
		end
	endtask

	function automatic brb_req_t make_request(input logic act, input int unsigned data,
			input int unsigned len);
		brb_req_t req;
		req.action = act;
		req.write_data = DATA_W'(data);
		req.read_length = LEN_W'(len);
		return req;
	endfunction

	// filling mood: mostly writes and tiny reads; otherwise reads of every size dominate
	function automatic brb_req_t random_request(input bit filling);
		brb_req_t    req;
		int unsigned pick;
		req.write_data = DATA_W'($urandom);
		req.read_length = LEN_W'($urandom);
		req.action = ($urandom_range(99) < (filling ? 90 : 40)) ? ACT_WRITE : ACT_READ;
		if (req.action == ACT_READ) begin
			pick = $urandom_range(9);
			if (filling) begin
				req.read_length = LEN_W'($urandom_range(4, 1));
			end else if (pick == 0) begin
				req.read_length = '0;
			end else if (pick == 1) begin
				req.read_length = LEN_W'($urandom_range(127, BURST_MAX + 1));
			end else if (pick == 2) begin
				req.read_length = LEN_W'($urandom_range(BURST_MAX, 9));
			end else begin
				req.read_length = LEN_W'($urandom_range(8, 1));
			end
		end
		return req;
	endfunction

	// entered at a rising edge; returns at the edge that takes the request
	// start stays high on return so back-to-back requests need no extra step
	task automatic send_request(input brb_req_t req);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			item <= random_request(1'b0);
			@(posedge clk);
		end
		start <= 1'b1;
		item <= req;
		do begin
			@(posedge clk);
		end while (busy);
		predict_ring_access(req);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("field %s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// every strobed result is matched against the oldest owed result
	always @(posedge clk) begin
		brb_rsp_t want;
		if (arst_n && strobe) begin
			if (awaited_rsp.size() == 0) begin
				$error("unexpected result: accepted %0d read_byte %0d last %0d used_count %0d",
					result.accepted, result.read_byte, result.last, result.used_count);
				fail_count++;
			end else begin
				want = awaited_rsp.pop_front();
				check_field("accepted", want.accepted, result.accepted);
				check_field("read_byte", want.read_byte, result.read_byte);
				check_field("last", want.last, result.last);
				check_field("used_count", want.used_count, result.used_count);
			end
		end
	end

	// hard stop in case the block hangs or stops producing results
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("byte_ring_buffer_fifo regression: fail");
			$finish;
		end
	end

	// empty reads, extreme bytes, zero-length and short reads
	task automatic test_directed_cases();
		idle_pct = 0;
		send_request(make_request(ACT_READ, 8'hFF, 0));
		send_request(make_request(ACT_READ, 8'h00, 127));
		send_request(make_request(ACT_WRITE, 8'h00, 127));
		send_request(make_request(ACT_WRITE, 8'hFF, 0));
		send_request(make_request(ACT_WRITE, 8'hA5, 64));
		send_request(make_request(ACT_WRITE, 8'h5A, 1));
		send_request(make_request(ACT_WRITE, 8'h80, 65));
		send_request(make_request(ACT_WRITE, 8'h01, 42));
		send_request(make_request(ACT_READ, 8'hFF, 0));
		send_request(make_request(ACT_READ, 8'h00, 1));
		send_request(make_request(ACT_READ, 8'h55, 2));
		// fewer held than asked: last lands on the final held byte
		send_request(make_request(ACT_READ, 8'hAA, 64));
		send_request(make_request(ACT_READ, 8'h00, 1));
		send_request(make_request(ACT_WRITE, 8'h7F, 0));
		send_request(make_request(ACT_READ, 8'h00, 127));
	endtask

	// fill to the brim, push past it, then drain with saturated bursts
	task automatic test_full_and_overflow();
		brb_req_t    req;
		int unsigned room;
		idle_pct = 24;
		room = RING_DEPTH - copy_used();
		for (int unsigned i = 0; i < room; i++) begin
			req = random_request(1'b1);
			req.action = ACT_WRITE;
			send_request(req);
		end
		send_request(make_request(ACT_WRITE, 8'hFF, 0));
		send_request(make_request(ACT_WRITE, 8'h00, 127));
		send_request(make_request(ACT_READ, 8'h00, 0));
		// saturates to a full burst and clears the full flag
		send_request(make_request(ACT_READ, 8'hFF, 127));
		send_request(make_request(ACT_WRITE, 8'hC3, 0));
		while (copy_used() != 0) begin
			send_request(make_request(ACT_READ, $urandom, BURST_MAX));
		end
		send_request(make_request(ACT_READ, 8'h00, BURST_MAX));
	endtask

	// mixed traffic in short runs of filling and draining, under each idling pattern
	task automatic test_random_traffic();
		int unsigned phase_idle [3] = '{0, 76, 24};
		bit          filling;
		filling = 1'b1;
		foreach (phase_idle[p]) begin
			idle_pct = phase_idle[p];
			for (int i = 0; i < 8; i++) begin
				if (i % 4 == 0) begin
					filling = $urandom_range(1);
				end
				send_request(random_request(filling));
			end
		end
	endtask

	initial begin
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_full_and_overflow();
		test_random_traffic();
		start <= 1'b0;
		while (awaited_rsp.size() != 0) begin
			@(posedge clk);
		end
		// anything arriving now is a stray result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("byte_ring_buffer_fifo regression: pass");
		end else begin
			$display("byte_ring_buffer_fifo regression: fail");
		end
		$finish;
	end

endmodule
